FILE: sv/dls_pkg.sv
// Shared types and constants for the dependency level scheduler.
// No dependencies; compiled first.
package dls_pkg;

	// Payload widths
	localparam int TASK_W   = 5;
	localparam int LEVEL_W  = 5;
	localparam int COUNT_W  = 6;

	// Most results that one process command can give
	localparam int RESULT_LIMIT = 32;

	// Command codes
	typedef enum logic [1:0] {
		OP_AFTER   = 2'd0,
		OP_BEFORE  = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_PROCESS = 2'd3
	} op_t;

endpackage

FILE: sv/dls_in_if.sv
// Command channel of the dependency level scheduler.
// Depends on dls_pkg.
interface dls_in_if;
	logic                          valid;
	logic                          ready;
	dls_pkg::op_t                  op;
	logic [dls_pkg::TASK_W-1:0]    subject_task;
	logic [dls_pkg::TASK_W-1:0]    other_task;

	modport source (output valid, output op, output subject_task, output other_task,
		input ready);
	modport sink (input valid, input op, input subject_task, input other_task,
		output ready);
endinterface

FILE: sv/dls_out_if.sv
// Result channel of the dependency level scheduler.
// Depends on dls_pkg.
interface dls_out_if;
	logic                          valid;
	logic                          ready;
	logic [dls_pkg::TASK_W-1:0]    task_id;
	logic [dls_pkg::LEVEL_W-1:0]   bucket_index;
	logic                          cycle_error;
	logic                          last;

	modport source (output valid, output task_id, output bucket_index,
		output cycle_error, output last, input ready);
	modport sink (input valid, input task_id, input bucket_index,
		input cycle_error, input last, output ready);
endinterface

FILE: sv/dependency_level_scheduler.sv
// Dependency level scheduler top level: edge memory, peeling sequencer, result register.
// Depends on dls_pkg, dls_in_if and dls_out_if.
//
// Edge commands add a "runs after" edge to a predecessor bit matrix held in a
// memory with one read and one write port (the row is read, then written back
// with the new bit); clear empties the matrix through per-row valid bits. A
// process command peels the graph in rounds: each round scans rows 0..n-1
// through the one memory read port, one row a cycle, and puts every task whose
// predecessors all sit in earlier rounds into the current bucket. A round that
// adds nothing while tasks remain means a cycle, and one error beat (task 0,
// bucket 0, last) is sent. Otherwise one beat per task follows, in task order,
// and the result side may stall the beats. The block takes no command until a
// process command has loaded its final beat; that beat may still wait in the
// output register while the next command is taken.
// n is task_count capped at MAX_TASKS and 32.
module dependency_level_scheduler #(
	parameter int MAX_TASKS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dls_in_if.sink                       in_ch,
	dls_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [dls_pkg::COUNT_W-1:0]  cfg_wdata
);

	localparam int ROWS  = (MAX_TASKS < dls_pkg::RESULT_LIMIT) ? MAX_TASKS
		: dls_pkg::RESULT_LIMIT;
	localparam int IW    = $clog2(ROWS);
	localparam int CW    = $clog2(ROWS) + 1;
	localparam int CNT_W = dls_pkg::COUNT_W;
	localparam int TW    = dls_pkg::TASK_W;
	localparam int LW    = dls_pkg::LEVEL_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_PEEL,
		S_EMIT,
		S_ERR
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    task_count_q;
	logic [CW-1:0]       cnt_q;
	logic                eval_v_s1;
	logic [IW-1:0]       eval_idx_s1;
	logic [ROWS-1:0]     row_s1;
	logic [ROWS-1:0]     done_q;
	logic [ROWS-1:0]     new_q;
	logic [LW-1:0]       round_q;
	logic [LW-1:0]       level_q [ROWS];
	logic [ROWS-1:0]     row_valid_q;
	logic [IW-1:0]       edge_row_q;
	logic [IW-1:0]       edge_bit_q;
	logic [ROWS-1:0]     pred_mem [ROWS];

	logic                out_valid_q;
	logic [TW-1:0]       out_task_q;
	logic [LW-1:0]       out_bucket_q;
	logic                out_err_q;
	logic                out_last_q;

	logic [CW-1:0]       n_eff;
	logic [ROWS-1:0]     col_mask;
	logic [TW-1:0]       later_task;
	logic [TW-1:0]       earlier_task;
	logic                edge_ok;
	logic [IW-1:0]       rd_addr;
	logic                mem_we;
	logic [ROWS-1:0]     mem_wdata;
	logic [ROWS-1:0]     eval_row;
	logic                eval_hit;
	logic                round_end;
	logic                out_load_ok;
	logic                in_acc;

	// Effective task count and its column mask
	assign n_eff = (task_count_q > CNT_W'(ROWS)) ? CW'(ROWS) : CW'(task_count_q);

	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			col_mask[j] = (CW'(j) < n_eff);
		end
	end

	// Edge decode: row is the later task, column the earlier one
	assign later_task   = (in_ch.op == dls_pkg::OP_AFTER) ? in_ch.subject_task
		: in_ch.other_task;
	assign earlier_task = (in_ch.op == dls_pkg::OP_AFTER) ? in_ch.other_task
		: in_ch.subject_task;
	assign edge_ok = (CNT_W'(later_task) < CNT_W'(n_eff))
		&& (CNT_W'(earlier_task) < CNT_W'(n_eff));

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// Memory port: edge read in idle, row scan while peeling
	assign rd_addr   = (state_q == S_PEEL) ? cnt_q[IW-1:0] : later_task[IW-1:0];
	assign mem_we    = (state_q == S_EDGE);
	assign mem_wdata = (row_valid_q[edge_row_q] ? row_s1 : '0)
		| (ROWS'(1) << edge_bit_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pred_mem[edge_row_q] <= mem_wdata;
		end
		row_s1 <= pred_mem[rd_addr];
	end

	// Task is ready when all its in-range predecessors sit in earlier rounds
	assign eval_row  = row_valid_q[eval_idx_s1] ? row_s1 : '0;
	assign eval_hit  = eval_v_s1 && !done_q[eval_idx_s1]
		&& ((eval_row & col_mask & ~done_q) == '0);
	assign round_end = !eval_v_s1 && (cnt_q == n_eff);

	assign out_load_ok = !out_valid_q || out_ch.ready;

	// Bucket store
	always_ff @(posedge clk) begin
		if (eval_hit) begin
			level_q[eval_idx_s1] <= round_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
		end else if (cfg_we) begin
			task_count_q <= cfg_wdata;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			eval_v_s1    <= 1'b0;
			eval_idx_s1  <= '0;
			done_q       <= '0;
			new_q        <= '0;
			round_q      <= '0;
			row_valid_q  <= '0;
			edge_row_q   <= '0;
			edge_bit_q   <= '0;
			out_valid_q  <= 1'b0;
			out_task_q   <= '0;
			out_bucket_q <= '0;
			out_err_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			// emit states either load a new beat or see ready low
			if (out_ch.ready && !(state_q inside {S_EMIT, S_ERR})) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_ch.op)
							dls_pkg::OP_AFTER, dls_pkg::OP_BEFORE: begin
								edge_row_q <= later_task[IW-1:0];
								edge_bit_q <= earlier_task[IW-1:0];
								if (edge_ok) begin
									state_q <= S_EDGE;
								end
							end
							dls_pkg::OP_CLEAR: begin
								row_valid_q <= '0;
							end
							dls_pkg::OP_PROCESS: begin
								cnt_q     <= '0;
								done_q    <= '0;
								new_q     <= '0;
								round_q   <= '0;
								eval_v_s1 <= 1'b0;
								if (n_eff != '0) begin
									state_q <= S_PEEL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EDGE: begin
					row_valid_q[edge_row_q] <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PEEL: begin
					// issue side
					if (cnt_q != n_eff) begin
						cnt_q       <= cnt_q + 1'b1;
						eval_v_s1   <= 1'b1;
						eval_idx_s1 <= cnt_q[IW-1:0];
					end else begin
						eval_v_s1 <= 1'b0;
					end
					// evaluate side
					if (eval_hit) begin
						new_q[eval_idx_s1] <= 1'b1;
					end
					// round wrap-up
					if (round_end) begin
						cnt_q <= '0;
						if ((done_q | new_q) == col_mask) begin
							state_q <= S_EMIT;
						end else if (new_q == '0) begin
							state_q <= S_ERR;
						end else begin
							done_q  <= done_q | new_q;
							new_q   <= '0;
							round_q <= round_q + 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_load_ok) begin
						out_valid_q  <= 1'b1;
						out_task_q   <= TW'(cnt_q);
						out_bucket_q <= level_q[cnt_q[IW-1:0]];
						out_err_q    <= 1'b0;
						out_last_q   <= (CW'(cnt_q + 1'b1) == n_eff);
						cnt_q        <= cnt_q + 1'b1;
						if (CW'(cnt_q + 1'b1) == n_eff) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (out_load_ok) begin
						out_valid_q  <= 1'b1;
						out_task_q   <= '0;
						out_bucket_q <= '0;
						out_err_q    <= 1'b1;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.task_id      = out_task_q;
	assign out_ch.bucket_index = out_bucket_q;
	assign out_ch.cycle_error  = out_err_q;
	assign out_ch.last         = out_last_q;

	// Checks

	// error beat is always a lone, final beat for task 0
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.cycle_error |-> out_ch.last && (out_ch.task_id == '0))
		else $error("error beat not marked last for task 0");

	// a non-empty process command holds off the next command
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_ch.op == dls_pkg::OP_PROCESS) && (n_eff != '0) |=> !in_ch.ready)
		else $error("command taken during processing");

	// while peeling, tasks enter a bucket once, and only tasks below the count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PEEL)
		|-> ((done_q & new_q) == '0) && ((done_q & ~col_mask) == '0))
		else $error("peel sets out of step");

	// a round only advances after a task was placed in it
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PEEL) && (round_q != $past(round_q)) && $past(state_q == S_PEEL)
		|-> $past(new_q != '0))
		else $error("empty round advanced");

endmodule
